FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers: one clock, one active-low reset, one message per check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one at the next rising edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/gift64_pkg.sv
// ----------------------------------------------------------------------------
// gift64_pkg
// Shared constants and round helper functions of the GIFT-64 encryptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gift64_pkg;

    localparam int BLOCK_W = 64;
    localparam int KEY_W   = 64;
    localparam int RC_W    = 6;
    localparam int RCNT_W  = 6;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [RCNT_W-1:0] ROUND_COUNT_RESET = 6'd28;

    // register indexes, taken from paddr[2]
    localparam logic REG_ROUND_COUNT = 1'b0;

    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'h1;
            4'h1: y = 4'hA;
            4'h2: y = 4'h4;
            4'h3: y = 4'hC;
            4'h4: y = 4'h6;
            4'h5: y = 4'hF;
            4'h6: y = 4'h3;
            4'h7: y = 4'h9;
            4'h8: y = 4'h2;
            4'h9: y = 4'hD;
            4'hA: y = 4'hB;
            4'hB: y = 4'h7;
            4'hC: y = 4'h5;
            4'hD: y = 4'h0;
            4'hE: y = 4'h8;
            default: y = 4'hE;
        endcase
        return y;
    endfunction

    // source position, MSB-first, of result bit i of the bit permutation
    function automatic int perm_pos(input int i);
        int grp;
        int col;
        int low;
        grp = i >> 4;
        col = (i & 15) >> 2;
        low = i & 3;
        return 4 * grp + 16 * ((3 * col + low) & 3) + low;
    endfunction

endpackage

`default_nettype wire

FILE: sv/gift64_round.sv
// ----------------------------------------------------------------------------
// gift64_round
// One GIFT-64 round: S-box layer, bit permutation, round key and constant,
// and the matching key state and constant LFSR update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gift64_round (
    input  wire logic [gift64_pkg::BLOCK_W-1:0] state_in,
    input  wire logic [gift64_pkg::KEY_W-1:0]   key_low_in,
    input  wire logic [gift64_pkg::KEY_W-1:0]   key_upper_in,
    input  wire logic [gift64_pkg::RC_W-1:0]    rc_in,
    output logic      [gift64_pkg::BLOCK_W-1:0] state_out,
    output logic      [gift64_pkg::KEY_W-1:0]   key_low_out,
    output logic      [gift64_pkg::KEY_W-1:0]   key_upper_out,
    output logic      [gift64_pkg::RC_W-1:0]    rc_out
);
    import gift64_pkg::*;

    logic [BLOCK_W-1:0] sub_w;
    logic [BLOCK_W-1:0] perm_w;
    logic [BLOCK_W-1:0] rkey_w;
    logic [15:0]        w0;
    logic [15:0]        w1;

    always_comb
    begin
        for (int n = 0; n < 16; n++)
        begin
            sub_w[4*n +: 4] = sbox(state_in[4*n +: 4]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 64; i++)
        begin
            perm_w[63-i] = sub_w[63-perm_pos(i)];
        end
    end

    assign rc_out = {rc_in[4:0], 1'b1 ^ rc_in[4] ^ rc_in[5]};

    always_comb
    begin
        rkey_w = '0;
        for (int i = 0; i < 16; i++)
        begin
            rkey_w[4*i]   = key_low_in[i];
            rkey_w[4*i+1] = key_low_in[16+i];
        end
        for (int i = 0; i < RC_W; i++)
        begin
            rkey_w[3+4*i] = rc_out[i];
        end
        rkey_w[63] = 1'b1;
    end

    assign state_out = perm_w ^ rkey_w;

    assign w0 = key_low_in[15:0];
    assign w1 = key_low_in[31:16];

    assign key_low_out   = {key_upper_in[31:0], key_low_in[63:32]};
    assign key_upper_out = {w1[1:0], w1[15:2], w0[11:0], w0[15:12], key_upper_in[63:32]};

endmodule

`default_nettype wire

FILE: sv/gift64_cfg.sv
// ----------------------------------------------------------------------------
// gift64_cfg
// APB-style register port holding the round count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gift64_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [gift64_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [gift64_pkg::DATA_W-1:0]    pwdata,
    output logic      [gift64_pkg::DATA_W-1:0]    prdata,
    output logic                                  pready,
    output logic      [gift64_pkg::RCNT_W-1:0]    round_count
);
    import gift64_pkg::*;

    logic [RCNT_W-1:0] round_count_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_count_reg <= ROUND_COUNT_RESET;
        end
        else if (wr_en && (paddr[2] == REG_ROUND_COUNT))
        begin
            round_count_reg <= pwdata[RCNT_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ROUND_COUNT: prdata = {{(DATA_W-RCNT_W){1'b0}}, round_count_reg};
            default:         prdata = '0;
        endcase
    end

    assign round_count = round_count_reg;

endmodule

`default_nettype wire

FILE: sv/gift64_block_encrypt.sv
// ----------------------------------------------------------------------------
// gift64_block_encrypt
// GIFT-64 block encryption with a 128-bit key, one round per clock cycle.
// ----------------------------------------------------------------------------
// Input channel: plaintext, key_low and key_upper under in_valid / in_stall.
// An item is taken when in_valid is high and in_stall low; in_stall then
// stays high while the shared round unit iterates over the block.
// Output channel: ciphertext under out_valid / out_stall, from an output
// register, so a new item is taken while a finished result waits.
// The block runs N rounds, N = round_count (N = 1 for a round count of
// zero), on the single round unit, and takes no new item until it has
// finished the block and returned to idle between blocks.
// A stalled result holds; if the output register is still full when the
// last round ends, the block keeps the result and waits before idling.
// Reset: idle, output empty, round_count = 28. Write round_count through
// the APB port at address 0 only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gift64_block_encrypt (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [gift64_pkg::BLOCK_W-1:0]   plaintext,
    input  wire logic [gift64_pkg::KEY_W-1:0]     key_low,
    input  wire logic [gift64_pkg::KEY_W-1:0]     key_upper,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [gift64_pkg::BLOCK_W-1:0]   ciphertext,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [gift64_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [gift64_pkg::DATA_W-1:0]    pwdata,
    output logic      [gift64_pkg::DATA_W-1:0]    prdata,
    output logic                                  pready
);
    import gift64_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [RCNT_W-1:0]  round_reg;
    logic [RC_W-1:0]    rc_reg;
    logic [BLOCK_W-1:0] s_reg;
    logic [KEY_W-1:0]   klo_reg;
    logic [KEY_W-1:0]   khi_reg;
    logic [BLOCK_W-1:0] ct_reg;
    logic [BLOCK_W-1:0] ct_next;

    logic [RCNT_W-1:0]  round_count;
    logic [BLOCK_W-1:0] rnd_state;
    logic [KEY_W-1:0]   rnd_klo;
    logic [KEY_W-1:0]   rnd_khi;
    logic [RC_W-1:0]    rnd_rc;
    logic               in_accept;
    logic               out_free;
    logic               last_round;
    logic               load_out;

    gift64_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .round_count (round_count)
    );

    gift64_round u_round (
        .state_in      (s_reg),
        .key_low_in    (klo_reg),
        .key_upper_in  (khi_reg),
        .rc_in         (rc_reg),
        .state_out     (rnd_state),
        .key_low_out   (rnd_klo),
        .key_upper_out (rnd_khi),
        .rc_out        (rnd_rc)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && (state_reg == ST_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign last_round = ({1'b0, round_reg} + 7'd1) >= {1'b0, round_count};

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        ct_next    = s_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                ct_next = rnd_state;
                if (last_round)
                begin
                    load_out   = out_free;
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                load_out = out_free;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            round_reg     <= '0;
            rc_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                round_reg <= '0;
                rc_reg    <= '0;
            end
            else if ((state_reg == ST_RUN) && !last_round)
            begin
                round_reg <= round_reg + 1'b1;
                rc_reg    <= rnd_rc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s_reg   <= plaintext;
            klo_reg <= key_low;
            khi_reg <= key_upper;
        end
        else if (state_reg == ST_RUN)
        begin
            s_reg   <= rnd_state;
            klo_reg <= rnd_klo;
            khi_reg <= rnd_khi;
        end
        if (load_out)
        begin
            ct_reg <= ct_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ciphertext = ct_reg;

endmodule

`default_nettype wire

FILE: sv/gift64_chk.sv
// ----------------------------------------------------------------------------
// gift64_chk
// Port-level checks of the GIFT-64 encryptor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gift64_chk (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic [gift64_pkg::BLOCK_W-1:0]   ciphertext
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(ciphertext), "stalled result changed")
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall,
                 "block not busy after taking an item")
    `ASSERT_ALWAYS(a_done_has_result, clk, rst_n, $fell(in_stall) |-> out_valid,
                   "block idled without a result")

endmodule

bind gift64_block_encrypt gift64_chk u_chk (.*);

`default_nettype wire

FILE: bench/gift64_block_encrypt_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gift64_block_encrypt_check
// Watches the plaintext and ciphertext channels and the register port of the
// GIFT-64 encryptor. Each accepted plaintext item is encrypted here under the
// tracked round count, and each accepted ciphertext item is compared with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module gift64_block_encrypt_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [gift64_pkg::BLOCK_W-1:0]   plaintext,
    input  logic [gift64_pkg::KEY_W-1:0]     key_low,
    input  logic [gift64_pkg::KEY_W-1:0]     key_upper,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [gift64_pkg::BLOCK_W-1:0]   ciphertext,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gift64_pkg::ADDR_W-1:0]    paddr,
    input  logic [gift64_pkg::DATA_W-1:0]    pwdata,
    input  logic                             pready,
    output int                               error_count,
    output int                               blocks_pending,
    output int                               blocks_checked
);

    import gift64_pkg::*;

    localparam logic [3:0] GIFT_SBOX [16] = '{
        4'h1, 4'hA, 4'h4, 4'hC, 4'h6, 4'hF, 4'h3, 4'h9,
        4'h2, 4'hD, 4'hB, 4'h7, 4'h5, 4'h0, 4'h8, 4'hE
    };

    logic [RCNT_W-1:0]  rounds_cfg;
    logic [BLOCK_W-1:0] cipher_q[$];
    logic [BLOCK_W-1:0] want;

    function automatic logic [BLOCK_W-1:0] gift_encrypt(
        input logic [BLOCK_W-1:0] blk,
        input logic [KEY_W-1:0]   klo_in,
        input logic [KEY_W-1:0]   khi_in,
        input logic [RCNT_W-1:0]  rounds
    );
        logic [BLOCK_W-1:0] s;
        logic [BLOCK_W-1:0] t;
        logic [BLOCK_W-1:0] rk;
        logic [KEY_W-1:0]   klo;
        logic [KEY_W-1:0]   khi;
        logic [15:0]        w0;
        logic [15:0]        w1;
        logic [RC_W-1:0]    rc;
        int                 r;
        int                 i;
        int                 src;
        int                 last;
        s    = blk;
        klo  = klo_in;
        khi  = khi_in;
        rc   = '0;
        last = (rounds == 0) ? 1 : int'(rounds);
        for (r = 0; r < last; r++)
        begin
            for (i = 0; i < 16; i++)
                t[4*i +: 4] = GIFT_SBOX[s[4*i +: 4]];
            for (i = 0; i < 64; i++)
            begin
                src = 4 * (i / 16) + 16 * ((3 * ((i % 16) / 4) + (i % 4)) % 4) + (i % 4);
                s[63-i] = t[63-src];
            end
            rc = {rc[4:0], 1'b1 ^ rc[4] ^ rc[5]};
            rk = '0;
            for (i = 0; i < 16; i++)
            begin
                rk[4*i]   = klo[i];
                rk[4*i+1] = klo[16+i];
            end
            for (i = 0; i < RC_W; i++)
                rk[3+4*i] = rc[i];
            rk[63] = 1'b1;
            s = s ^ rk;
            w0  = klo[15:0];
            w1  = klo[31:16];
            klo = {khi[31:0], klo[63:32]};
            khi = {w1[1:0], w1[15:2], w0[11:0], w0[15:12], khi[63:32]};
        end
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rounds_cfg     <= ROUND_COUNT_RESET;
            error_count    <= 0;
            blocks_pending <= 0;
            blocks_checked <= 0;
            cipher_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_ROUND_COUNT)
                rounds_cfg <= pwdata[RCNT_W-1:0];
            if (out_valid && !out_stall)
            begin
                if (cipher_q.size() == 0)
                begin
                    $display("%0t: ciphertext with nothing expected, actual %h",
                             $time, ciphertext);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = cipher_q.pop_front();
                    if (ciphertext !== want)
                    begin
                        $display("%0t: ciphertext expected %h actual %h",
                                 $time, want, ciphertext);
                        error_count <= error_count + 1;
                    end
                    blocks_checked <= blocks_checked + 1;
                end
            end
            if (in_valid && !in_stall)
                cipher_q.push_back(gift_encrypt(plaintext, key_low, key_upper, rounds_cfg));
            blocks_pending <= cipher_q.size();
        end
    end

endmodule

FILE: bench/gift64_block_encrypt_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gift64_block_encrypt_test
// Drives the GIFT-64 encryptor with directed and random blocks and keys over
// a series of round counts written through the register port, with random
// bursts of idle on the input and stall on the output.
// ----------------------------------------------------------------------------

module gift64_block_encrypt_test;

    import gift64_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 80;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [BLOCK_W-1:0]  plaintext;
    logic [KEY_W-1:0]    key_low;
    logic [KEY_W-1:0]    key_upper;
    logic                out_valid;
    logic                out_stall;
    logic [BLOCK_W-1:0]  ciphertext;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                calm;
    int                  error_count;
    int                  blocks_pending;
    int                  blocks_checked;
    int                  quiet_cycles;
    int                  phase_idx;
    int                  n;
    logic [RCNT_W-1:0]   phase_rounds [PHASES];

    gift64_block_encrypt i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .plaintext  (plaintext),
        .key_low    (key_low),
        .key_upper  (key_upper),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ciphertext (ciphertext),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    gift64_block_encrypt_check i_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .plaintext      (plaintext),
        .key_low        (key_low),
        .key_upper      (key_upper),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ciphertext     (ciphertext),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .error_count    (error_count),
        .blocks_pending (blocks_pending),
        .blocks_checked (blocks_checked)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic send_block(input logic [BLOCK_W-1:0] pt,
                              input logic [KEY_W-1:0] kl,
                              input logic [KEY_W-1:0] kh);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        plaintext <= pt;
        key_low   <= kl;
        key_upper <= kh;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        do @(negedge clk); while (blocks_pending != 0);
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // hold stall for random bursts, none once the run calms down
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!calm && rst_n && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("gift64_block_encrypt: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        plaintext    = '0;
        key_low      = '0;
        key_upper    = '0;
        out_stall    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        calm         = 1'b0;
        quiet_cycles = 0;
        phase_rounds = '{6'd1, 6'd48, 6'd0, 6'd63, 6'd0, 6'd0, 6'd0, 6'd28, 6'd0, 6'd5};
        for (n = 0; n < PHASES; n++)
            if (n inside {4, 5, 6, 8})
                phase_rounds[n] = RCNT_W'($urandom_range(2, 47));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_block(64'h0, 64'h0, 64'h0);
        send_block('1, '1, '1);
        send_block('1, 64'h0, 64'h0);
        send_block(64'h0, '1, '1);
        send_block(64'h0, '1, 64'h0);
        send_block(64'h0, 64'h0, '1);
        send_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_block(64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF, 64'h0F1E_2D3C_4B5A_6978);
        send_block(64'h8000_0000_0000_0001, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
        send_block(64'h0000_0000_0000_0001, 64'h0000_0000_0000_8001, 64'h8000_0000_0000_0000);
        send_block(64'h8000_0000_0000_0000, 64'h0000_0000_C003_0000, 64'h0000_0000_0000_0001);
        send_block(64'h0123_4567_89AB_CDEF, 64'h0, 64'h0);
        send_block(64'h0, 64'hFFFF_0000_0000_FFFF, 64'h0000_FFFF_FFFF_0000);
        drain();

        for (phase_idx = 0; phase_idx < PHASES; phase_idx++)
        begin
            reg_write({REG_ROUND_COUNT, 2'b00},
                      ($urandom & ~32'h3F) | DATA_W'(phase_rounds[phase_idx]));
            if (phase_idx == 3)
                reg_write({~REG_ROUND_COUNT, 2'b00}, $urandom);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase_idx == PHASES - 1 && n == PHASE_ITEMS / 2)
                    calm = 1'b1;
                send_block(pick_word(), pick_word(), pick_word());
            end
            drain();
        end

        repeat (80) @(posedge clk);
        $display("encrypted %0d blocks under %0d round-count settings, incl. 0, 1, 48 and 63,",
                 blocks_checked, PHASES + 1);
        $display("with random input gaps and output stalls and a final stretch without either");
        if (error_count == 0)
            $display("gift64_block_encrypt: match");
        else
            $display("gift64_block_encrypt: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/gift64_pkg.sv
sv/gift64_round.sv
sv/gift64_cfg.sv
sv/gift64_block_encrypt.sv
sv/gift64_chk.sv
bench/gift64_block_encrypt_check.sv
bench/gift64_block_encrypt_test.sv
